// File: sv/fbpa_pkg.sv
package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS     = 256;
  localparam int unsigned LINK_BYTES_DEF = 4;

  localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS);
  localparam int unsigned LINK_W    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  // rounded size may reach one past the 16-bit range before the size check
  localparam int unsigned RND_W     = SIZE_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_PUT  = 2'd1,
    OP_INIT = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BADPUT = 3'd2,
    ST_SMALL  = 3'd3,
    ST_NOINIT = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_POOL_BYTES  = 2'd1,
    CFG_BLOCK_BYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ROUND,
    S_COUNT,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] block_index;
  } in_req_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] granted_addr;
    logic [LINK_W-1:0] free_count;
    logic [LINK_W-1:0] low_mark;
    logic [LINK_W-1:0] total_blocks;
    logic [SIZE_W-1:0] rounded_size;
  } out_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    wdata;
  } cfg_wr_t;

endpackage

// File: sv/fbpa_chan_if.sv
interface fbpa_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/fbpa_div.sv
// Restoring divider, one quotient bit per cycle. done pulses in the cycle
// after the last step; quo holds until the next start.
module fbpa_div #(
  parameter int unsigned W = fbpa_pkg::RND_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  den_r;
  logic [W:0]    trial;
  logic [W+1:0]  diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};

  always_comb begin
    if (!diff[W+1]) begin
      rem_nxt = diff[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  ap_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider started while busy");

  ap_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");

  ap_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CW'(W - 1)) |=> done_r)
    else $error("divider missed its last step");

endmodule

// File: sv/fixed_block_pool_allocator.sv
// Channel  | dir | payload                                      | note
// in_chan  | in  | opcode, block_index                          | one request at a time
// out_chan | out | status, granted_index/addr, counts, size     | registered result
// cfg_chan | in  | index, wdata                                 | always ready, write when idle
//
// Get, put and the unused opcode are accepted in S_IDLE (link memory read is issued
// at the head), then S_EXEC writes back and loads the result once the output register is free.
// Init rounds the size in S_ROUND (reciprocal multiply by the link size), runs
// the divider for the block count in S_COUNT, then writes one link per cycle in
// S_FILL before S_DONE loads the result; a failed init goes from S_ROUND to S_DONE.
// A new request is accepted as soon as the previous result is loaded, even if
// out_chan is still stalled; a finished result waits in its state for a free
// output register. Reset is synchronous, active low; link memory is not cleared.
module fixed_block_pool_allocator #(
  parameter int unsigned LINK_BYTES = fbpa_pkg::LINK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fbpa_chan_if.sink   in_chan,
  fbpa_chan_if.source out_chan,
  fbpa_chan_if.sink   cfg_chan
);

  localparam int unsigned IDX_W  = fbpa_pkg::IDX_W;
  localparam int unsigned LINK_W = fbpa_pkg::LINK_W;
  localparam int unsigned ADDR_W = fbpa_pkg::ADDR_W;
  localparam int unsigned SIZE_W = fbpa_pkg::SIZE_W;
  localparam int unsigned RND_W  = fbpa_pkg::RND_W;
  localparam int unsigned PROD_W = IDX_W + SIZE_W;

  // exact floor(n / LINK_BYTES) for n below 2^RND_W: (n * RCP) >> RCP_SH
  localparam int unsigned RCP_SH = RND_W + $clog2(LINK_BYTES);
  localparam int unsigned RCP_W  = RND_W + 1;
  localparam int unsigned RPRD_W = RCP_SH + RND_W + 1;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(LINK_BYTES) - 64'd1) / 64'(LINK_BYTES));

  // configuration registers
  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] pool_r;
  logic [SIZE_W-1:0] blk_r;

  // allocator state
  fbpa_pkg::state_t  state_r, state_nxt;
  logic              ready_r, ready_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] free_r, free_nxt;
  logic [LINK_W-1:0] mark_r, mark_nxt;
  logic [LINK_W-1:0] total_r, total_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  // request and init scratch
  fbpa_pkg::in_req_t req_r;
  logic [RND_W-1:0]  rnd_r;
  logic [LINK_W-1:0] n_r;
  logic              init_ok_r;
  logic [IDX_W-1:0]  fill_idx_r;
  logic              fill_last;

  // link memory, one entry per block
  logic [LINK_W-1:0] link_mem [fbpa_pkg::MAX_BLOCKS];
  logic [LINK_W-1:0] rd_link_r;
  logic              rd_en;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;

  // output register
  logic               out_valid_r;
  fbpa_pkg::out_rsp_t out_data_r;
  fbpa_pkg::out_rsp_t rsp;
  logic               out_free;

  // control
  logic in_ready, in_fire;
  logic commit;
  logic fill_we;
  logic put_ok;

  // size rounding and divider hookup
  logic [RND_W-1:0]  rnd_num, rnd_quo;
  logic [RPRD_W-1:0] rnd_prod;
  logic             div_start, div_done;
  logic [RND_W-1:0] div_num, div_den, div_quo;
  logic [RND_W-1:0] rnd_mul, rnd_calc;
  logic             too_small;
  logic [LINK_W-1:0] n_calc;
  logic [PROD_W-1:0] gprod;

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_fire  = in_chan.valid && in_ready;
  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // ---------------------------------------------------------------
  // configuration writes; index 3 is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      pool_r <= '0;
      blk_r  <= '0;
    end else if (cfg_chan.valid) begin
      unique case (fbpa_pkg::cfg_idx_t'(cfg_chan.data.index))
        fbpa_pkg::CFG_POOL_BASE:   base_r <= cfg_chan.data.wdata;
        fbpa_pkg::CFG_POOL_BYTES:  pool_r <= cfg_chan.data.wdata[SIZE_W-1:0];
        fbpa_pkg::CFG_BLOCK_BYTES: blk_r  <= cfg_chan.data.wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // init arithmetic: size = ceil(blk / L) * L, at least L; count = pool / size
  assign rnd_num  = RND_W'(blk_r) + RND_W'(LINK_BYTES - 1);
  assign rnd_prod = RPRD_W'(rnd_num) * RPRD_W'(RCP);
  assign rnd_quo  = rnd_prod[RCP_SH +: RND_W];
  assign rnd_mul  = rnd_quo * RND_W'(LINK_BYTES);
  assign rnd_calc = (rnd_mul < RND_W'(LINK_BYTES)) ? RND_W'(LINK_BYTES) : rnd_mul;
  // pool below one link, size beyond 16 bits, or pool below one block
  assign too_small = (RND_W'(pool_r) < RND_W'(LINK_BYTES)) || rnd_calc[RND_W-1]
                     || (RND_W'(pool_r) < rnd_calc);

  assign div_num = RND_W'(pool_r);
  assign div_den = rnd_calc;
  assign n_calc = (div_quo > RND_W'(fbpa_pkg::MAX_BLOCKS))
                  ? fbpa_pkg::LINK_NIL : div_quo[LINK_W-1:0];

  fbpa_div #(
    .W (RND_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign fill_last = (LINK_W'(fill_idx_r) == n_r - LINK_W'(1));

  // ---------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbpa_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_chan.data.opcode == fbpa_pkg::OP_INIT)
                      ? fbpa_pkg::S_ROUND : fbpa_pkg::S_EXEC;
        end
      end
      fbpa_pkg::S_EXEC:  if (out_free) state_nxt = fbpa_pkg::S_IDLE;
      fbpa_pkg::S_ROUND: state_nxt = too_small ? fbpa_pkg::S_DONE : fbpa_pkg::S_COUNT;
      fbpa_pkg::S_COUNT: if (div_done) state_nxt = fbpa_pkg::S_FILL;
      fbpa_pkg::S_FILL:  if (fill_last) state_nxt = fbpa_pkg::S_DONE;
      fbpa_pkg::S_DONE:  if (out_free) state_nxt = fbpa_pkg::S_IDLE;
      default:           state_nxt = fbpa_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    rd_en     = 1'b0;
    fill_we   = 1'b0;
    unique case (state_r)
      fbpa_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        rd_en     = in_fire;
      end
      fbpa_pkg::S_EXEC:  commit    = out_free;
      fbpa_pkg::S_ROUND: div_start = !too_small;
      fbpa_pkg::S_COUNT: ;
      fbpa_pkg::S_FILL:  fill_we   = 1'b1;
      fbpa_pkg::S_DONE:  commit    = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // result and state update for the request being finished
  assign gprod = PROD_W'(head_r[IDX_W-1:0]) * PROD_W'(size_r);

  always_comb begin
    head_nxt  = head_r;
    free_nxt  = free_r;
    mark_nxt  = mark_r;
    total_nxt = total_r;
    size_nxt  = size_r;
    ready_nxt = ready_r;
    put_ok    = 1'b0;
    rsp       = '0;
    rsp.status = fbpa_pkg::ST_OK;
    if (state_r == fbpa_pkg::S_DONE) begin
      if (init_ok_r) begin
        head_nxt  = '0;
        free_nxt  = n_r;
        mark_nxt  = n_r;
        total_nxt = n_r;
        size_nxt  = rnd_r[SIZE_W-1:0];
        ready_nxt = 1'b1;
      end else begin
        // failed init leaves the allocator as after reset
        head_nxt   = fbpa_pkg::LINK_NIL;
        free_nxt   = '0;
        mark_nxt   = '0;
        total_nxt  = '0;
        size_nxt   = '0;
        ready_nxt  = 1'b0;
        rsp.status = fbpa_pkg::ST_SMALL;
      end
    end else if (!ready_r) begin
      rsp.status = fbpa_pkg::ST_NOINIT;
    end else begin
      unique case (req_r.opcode)
        fbpa_pkg::OP_GET: begin
          if (head_r >= fbpa_pkg::LINK_NIL || free_r == '0) begin
            rsp.status = fbpa_pkg::ST_EMPTY;
          end else begin
            rsp.granted_index = head_r[IDX_W-1:0];
            rsp.granted_addr  = base_r + ADDR_W'(gprod);
            head_nxt = rd_link_r;
            free_nxt = free_r - LINK_W'(1);
            if (mark_r > free_nxt) mark_nxt = free_nxt;
          end
        end
        fbpa_pkg::OP_PUT: begin
          if (LINK_W'(req_r.block_index) >= total_r || free_r >= total_r) begin
            rsp.status = fbpa_pkg::ST_BADPUT;
          end else begin
            put_ok   = 1'b1;
            head_nxt = LINK_W'(req_r.block_index);
            free_nxt = free_r + LINK_W'(1);
          end
        end
        fbpa_pkg::OP_INIT, fbpa_pkg::OP_NONE: ;
      endcase
    end
    rsp.free_count   = free_nxt;
    rsp.low_mark     = mark_nxt;
    rsp.total_blocks = total_nxt;
    rsp.rounded_size = size_nxt;
  end

  // ---------------------------------------------------------------
  // link memory: one write port (fill or put), one registered read at head
  assign mem_we    = fill_we || (commit && put_ok);
  assign mem_waddr = fill_we ? fill_idx_r : req_r.block_index;
  assign mem_wdata = fill_we ? (fill_last ? fbpa_pkg::LINK_NIL
                                          : LINK_W'(fill_idx_r) + LINK_W'(1))
                             : head_r;

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_link_r <= link_mem[head_r[IDX_W-1:0]];
  end

  // ---------------------------------------------------------------
  // control and allocator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      ready_r     <= 1'b0;
      head_r      <= fbpa_pkg::LINK_NIL;
      free_r      <= '0;
      mark_r      <= '0;
      total_r     <= '0;
      size_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        ready_r     <= ready_nxt;
        head_r      <= head_nxt;
        free_r      <= free_nxt;
        mark_r      <= mark_nxt;
        total_r     <= total_nxt;
        size_r      <= size_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_chan.data;
    if (commit) out_data_r <= rsp;
    if (state_r == fbpa_pkg::S_ROUND) begin
      rnd_r     <= rnd_calc;
      init_ok_r <= !too_small;
    end
    if (state_r == fbpa_pkg::S_COUNT && div_done) begin
      n_r        <= n_calc;
      fill_idx_r <= '0;
    end else if (fill_we) begin
      fill_idx_r <= fill_idx_r + IDX_W'(1);
    end
  end

  // ---------------------------------------------------------------
  ap_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= total_r)
    else $error("free count above total");

  ap_mark_le_free: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= free_r)
    else $error("low watermark above free count");

  ap_uninit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_r |-> (head_r == fbpa_pkg::LINK_NIL && free_r == '0 && total_r == '0))
    else $error("state not clear while uninitialized");

  ap_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == fbpa_pkg::S_IDLE && out_valid_r))
    else $error("finished request did not load the result");

  ap_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != fbpa_pkg::S_IDLE && !in_ready))
    else $error("accepted request left no work");

endmodule
